// File: design/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants for the shaded texture span rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package str_pkg;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 16;
  localparam int COORD_W    = 32;
  localparam int X_W        = 12;
  localparam int COUNT_W    = 7;
  localparam int TEXEL_W    = 8;
  localparam int COLOR_W    = 16;
  localparam int LOG_W      = 4;
  localparam int MASK_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int ERR_W      = 16;

  // Texel store is always 64K entries; the texel offset wraps to 16 bits.
  localparam int TEX_AW    = 16;
  localparam int TEX_DEPTH = 1 << TEX_AW;
  // Colours per shade row, selected by the low six texel bits.
  localparam int ROW_COLS  = 64;
  localparam int COLOUR_W  = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [LOG_W-1:0]  CFG_LOG_RESET  = 4'd8;
  localparam logic [MASK_W-1:0] CFG_MASK_RESET = 31'h003F_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEX_WR   = 2'd0,
    CMD_SHADE_WR = 2'd1,
    CMD_DRAW     = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LOG    = 3'd0,
    CFG_HEIGHT_LOG   = 3'd1,
    CFG_DITHER_EN    = 3'd2,
    CFG_SHADE_MASK_0 = 3'd3,
    CFG_SHADE_MASK_1 = 3'd4,
    CFG_SHADE_MASK_2 = 3'd5,
    CFG_SHADE_MASK_3 = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DRAW = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [LOG_W-1:0]             width_log;
    logic [LOG_W-1:0]             height_log;
    logic                         dither_enable;
    logic [3:0][MASK_W-1:0]       shade_mask;
  } cfg_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_t                 cmd;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    write_data;
    logic [COORD_W-1:0]   u_start;
    logic [COORD_W-1:0]   v_start;
    logic [COORD_W-1:0]   d_start;
    logic [COORD_W-1:0]   u_step;
    logic [COORD_W-1:0]   v_step;
    logic [COORD_W-1:0]   d_step;
    logic [X_W-1:0]       start_x;
    logic [COUNT_W-1:0]   pixel_count;
    logic                 new_span;
  } entry_t;

endpackage

`default_nettype wire

// File: design/str_front.sv
// ----------------------------------------------------------------------------
// str_front
// Input stage: takes commands, drops the ones with no effect and saturates
// the pixel count, then hands the entry to the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module str_front #(
  parameter int SHADE_ROWS = 64,
  parameter int MAX_SPAN   = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [str_pkg::CMD_W-1:0]      in_command,
  input  logic [str_pkg::ADDR_W-1:0]     in_address,
  input  logic [str_pkg::DATA_W-1:0]     in_write_data,
  input  logic signed [str_pkg::COORD_W-1:0] in_u_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_v_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_d_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_u_step,
  input  logic signed [str_pkg::COORD_W-1:0] in_v_step,
  input  logic signed [str_pkg::COORD_W-1:0] in_d_step,
  input  logic [str_pkg::X_W-1:0]        in_start_x,
  input  logic [str_pkg::COUNT_W-1:0]    in_pixel_count,
  input  logic                           in_new_span,
  output logic                           push_valid,
  output str_pkg::entry_t                push_entry,
  input  logic                           push_ready
);
  import str_pkg::*;

  localparam int SHADE_DEPTH = 4 * SHADE_ROWS * ROW_COLS;

  logic   fr_valid_r, fr_valid_nxt;
  entry_t fr_entry_r, fr_entry_nxt;
  logic   accept;
  logic   keep;
  entry_t cls;

  assign in_stall   = fr_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = fr_valid_r;
  assign push_entry = fr_entry_r;

  always_comb begin
    cls.cmd         = cmd_t'(in_command);
    cls.address     = in_address;
    cls.write_data  = in_write_data;
    cls.u_start     = in_u_start;
    cls.v_start     = in_v_start;
    cls.d_start     = in_d_start;
    cls.u_step      = in_u_step;
    cls.v_step      = in_v_step;
    cls.d_step      = in_d_step;
    cls.start_x     = in_start_x;
    cls.pixel_count = (in_pixel_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN)
                                                             : in_pixel_count;
    cls.new_span    = in_new_span;

    // Out-of-range shade writes, empty draws and the unused code are dropped here.
    case (in_command)
      CMD_TEX_WR:   keep = 1'b1;
      CMD_SHADE_WR: keep = ({1'b0, in_address} < 17'(SHADE_DEPTH));
      CMD_DRAW:     keep = (in_pixel_count != '0);
      default:      keep = 1'b0;
    endcase
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_entry_nxt = fr_entry_r;
    if (accept) begin
      fr_valid_nxt = keep;
      fr_entry_nxt = cls;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_entry_r <= fr_entry_nxt;
  end

endmodule

`default_nettype wire

// File: design/str_queue.sv
// ----------------------------------------------------------------------------
// str_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module str_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  str_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            head_valid,
  output str_pkg::entry_t head_entry,
  input  logic            pop
);
  import str_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: design/str_back.sv
// ----------------------------------------------------------------------------
// str_back
// Command executor: memory writes, the span sequencer and the pixel pipeline
// (texel read, shade row select, row modulo, shade read into the output).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module str_back #(
  parameter int TEX_LOG_MAX = 8,
  parameter int SHADE_ROWS  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  str_pkg::cfg_t                cfg,
  input  logic                         head_valid,
  input  str_pkg::entry_t              head_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [str_pkg::X_W-1:0]      out_pixel_x,
  output logic [str_pkg::COLOR_W-1:0]  out_color,
  output logic                         out_last
);
  import str_pkg::*;

  localparam int TABLE_SIZE  = SHADE_ROWS * ROW_COLS;
  localparam int SHADE_DEPTH = 4 * TABLE_SIZE;
  localparam int SH_AW       = $clog2(SHADE_DEPTH);
  localparam int ROW_W       = (SHADE_ROWS > 1) ? $clog2(SHADE_ROWS) : 1;
  localparam int RECIP       = 65536 / SHADE_ROWS;
  localparam logic [16:0] RECIP_C = 17'(RECIP);
  localparam logic [8:0]  ROWS_C  = 9'(SHADE_ROWS);
  localparam int IDX_W       = 15;
  localparam int RRAW_W      = 10;

  // Memories.
  logic [TEXEL_W-1:0] tex_mem_r [TEX_DEPTH];
  logic [COLOR_W-1:0] sh_mem_r  [SHADE_DEPTH];
  logic [TEXEL_W-1:0] tex_q_r;
  logic [COLOR_W-1:0] sh_q_r;

  // Sequencer state.
  back_state_t        st_r, st_nxt;
  logic [COORD_W-1:0] u_acc_r, u_acc_nxt;
  logic [COORD_W-1:0] v_acc_r, v_acc_nxt;
  logic [COORD_W-1:0] d_acc_r, d_acc_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [X_W-1:0]     col_r, col_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] u_step_r, u_step_nxt;
  logic [COORD_W-1:0] v_step_r, v_step_nxt;
  logic [COORD_W-1:0] d_step_r, d_step_nxt;
  logic               tex_we;
  logic               sh_we;
  logic               issue;

  // Pipeline.
  logic               en;
  logic               pipe_busy;
  logic               s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic [COORD_W-1:0] s1_dsum_r;
  logic [X_W-1:0]     s1_px_r, s2_px_r, s3_px_r, out_px_r;
  logic               s1_last_r, s2_last_r, s3_last_r, out_last_r;
  logic [1:0]         s2_tab_r, s3_tab_r;
  logic [COLOUR_W-1:0] s2_colour_r, s3_colour_r;
  logic [IDX_W-1:0]   s2_x_r;
  logic [31:0]        s2_prod_r;
  logic [RRAW_W-1:0]  s3_rraw_r;

  logic [LOG_W-1:0]   wl, hl;
  logic [15:0]        wmask, hmask;
  logic [31:0]        tex_off;
  logic [TEX_AW-1:0]  tex_raddr;
  logic [COORD_W-1:0] dsum_nxt;
  logic [1:0]         tab_nxt;
  logic [MASK_W-1:0]  masked;
  logic [IDX_W-1:0]   x_nxt;
  logic [31:0]        prod_nxt;
  logic [IDX_W-1:0]   quot;
  logic [23:0]        rraw_full;
  logic [RRAW_W-1:0]  rrow_full;
  logic [ROW_W-1:0]   srow;
  logic [16:0]        sh_addr_full;
  logic [SH_AW-1:0]   sh_raddr;

  // The whole pipeline moves together whenever the output register can take a pixel.
  assign en        = !out_valid_r || !out_stall;
  assign pipe_busy = s1_valid_r || s2_valid_r || s3_valid_r || out_valid_r;

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_px_r;
  assign out_color   = sh_q_r;
  assign out_last    = out_last_r;

  // Texel address from the wrapped coordinates.
  always_comb begin
    wl        = (cfg.width_log  > LOG_W'(TEX_LOG_MAX)) ? LOG_W'(TEX_LOG_MAX) : cfg.width_log;
    hl        = (cfg.height_log > LOG_W'(TEX_LOG_MAX)) ? LOG_W'(TEX_LOG_MAX) : cfg.height_log;
    wmask     = 16'((32'd1 << wl) - 32'd1);
    hmask     = 16'((32'd1 << hl) - 32'd1);
    tex_off   = ({16'd0, v_acc_r[31:16] & hmask} << wl) | {16'd0, u_acc_r[31:16] & wmask};
    tex_raddr = tex_off[TEX_AW-1:0];
    dsum_nxt  = d_acc_r + {16'd0, err_r};
  end

  // Shade row: masked integer part, then modulo the row count by reciprocal.
  always_comb begin
    tab_nxt   = tex_q_r[7:6];
    masked    = s1_dsum_r[MASK_W-1:0] & cfg.shade_mask[tab_nxt];
    x_nxt     = masked[30:16];
    prod_nxt  = {17'd0, x_nxt} * {15'd0, RECIP_C};
    quot      = s2_prod_r[30:16];
    rraw_full = {9'd0, s2_x_r} - ({9'd0, quot} * {15'd0, ROWS_C});
    // The estimate is low by at most one, so one subtract finishes it.
    rrow_full = (s3_rraw_r >= {1'b0, ROWS_C}) ? s3_rraw_r - {1'b0, ROWS_C} : s3_rraw_r;
    srow      = rrow_full[ROW_W-1:0];
    sh_addr_full = ({15'd0, s3_tab_r} * 17'(TABLE_SIZE))
                 + ({{(17-ROW_W){1'b0}}, srow} << COLOUR_W)
                 + {11'd0, s3_colour_r};
    sh_raddr  = sh_addr_full[SH_AW-1:0];
  end

  // Sequencer.
  always_comb begin
    st_nxt     = st_r;
    u_acc_nxt  = u_acc_r;
    v_acc_nxt  = v_acc_r;
    d_acc_nxt  = d_acc_r;
    err_nxt    = err_r;
    col_nxt    = col_r;
    rem_nxt    = rem_r;
    u_step_nxt = u_step_r;
    v_step_nxt = v_step_r;
    d_step_nxt = d_step_r;
    pop        = 1'b0;
    tex_we     = 1'b0;
    sh_we      = 1'b0;
    issue      = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (head_valid) begin
          case (head_entry.cmd)
            CMD_TEX_WR: begin
              // Writes wait until pixels already in flight have read the memories.
              if (!pipe_busy) begin
                tex_we = 1'b1;
                pop    = 1'b1;
              end
            end
            CMD_SHADE_WR: begin
              if (!pipe_busy) begin
                sh_we = 1'b1;
                pop   = 1'b1;
              end
            end
            CMD_DRAW: begin
              pop        = 1'b1;
              rem_nxt    = head_entry.pixel_count;
              u_step_nxt = head_entry.u_step;
              v_step_nxt = head_entry.v_step;
              d_step_nxt = head_entry.d_step;
              if (head_entry.new_span) begin
                u_acc_nxt = head_entry.u_start;
                v_acc_nxt = head_entry.v_start;
                d_acc_nxt = head_entry.d_start;
                col_nxt   = head_entry.start_x;
                err_nxt   = '0;
              end
              st_nxt = BK_DRAW;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BK_DRAW: begin
        if (en) begin
          issue     = 1'b1;
          u_acc_nxt = u_acc_r + u_step_r;
          v_acc_nxt = v_acc_r + v_step_r;
          d_acc_nxt = d_acc_r + d_step_r;
          col_nxt   = col_r + 1'b1;
          // With dither on, error adds the low half of the stepped shade coordinate.
          err_nxt   = cfg.dither_enable ? (err_r + d_acc_r[15:0] + d_step_r[15:0]) : '0;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == COUNT_W'(1)) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      u_acc_r <= '0;
      v_acc_r <= '0;
      d_acc_r <= '0;
      err_r   <= '0;
      col_r   <= '0;
      rem_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      u_acc_r <= u_acc_nxt;
      v_acc_r <= v_acc_nxt;
      d_acc_r <= d_acc_nxt;
      err_r   <= err_nxt;
      col_r   <= col_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_step_r <= u_step_nxt;
    v_step_r <= v_step_nxt;
    d_step_r <= d_step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dsum_r   <= dsum_nxt;
      s1_px_r     <= col_r;
      s1_last_r   <= (rem_r == COUNT_W'(1));
      s2_tab_r    <= tab_nxt;
      s2_colour_r <= tex_q_r[COLOUR_W-1:0];
      s2_x_r      <= x_nxt;
      s2_prod_r   <= prod_nxt;
      s2_px_r     <= s1_px_r;
      s2_last_r   <= s1_last_r;
      s3_rraw_r   <= rraw_full[RRAW_W-1:0];
      s3_tab_r    <= s2_tab_r;
      s3_colour_r <= s2_colour_r;
      s3_px_r     <= s2_px_r;
      s3_last_r   <= s2_last_r;
      out_px_r    <= s3_px_r;
      out_last_r  <= s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem_r[head_entry.address[TEX_AW-1:0]] <= head_entry.write_data[TEXEL_W-1:0];
    end
    if (en) begin
      tex_q_r <= tex_mem_r[tex_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      sh_mem_r[head_entry.address[SH_AW-1:0]] <= head_entry.write_data;
    end
    if (en) begin
      sh_q_r <= sh_mem_r[sh_raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/shaded_texture_span_rasterizer_top.sv
// ----------------------------------------------------------------------------
// shaded_texture_span_rasterizer_top
// Draws horizontal spans of 16-bit pixels from a wrapped 8-bit texture
// through four shade tables; also loads the texture and shade memories.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Moves
//  in_*     input      valid / stall    one command (texel write, shade write, draw)
//  out_*    output     valid / stall    one pixel: column, colour, last flag
//  cfg_*    input      valid / ready    one register write: index and data
//
//  A draw of N pixels holds the span sequencer for a load and N pixel issues, one pixel
//  per cycle while out_stall does not hold it; pixels pass s1, s2 and s3 to the
//  output register. A memory write waits until the pixel pipeline is empty.
//  Reset clears control state and loads register defaults; no clearing pass.
//  out_stall freezes the whole pixel pipeline; inputs keep transferring until
//  the front register and the two-entry command queue are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shaded_texture_span_rasterizer_top #(
  parameter int TEX_LOG_MAX = 8,
  parameter int SHADE_ROWS  = 64,
  parameter int MAX_SPAN    = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [str_pkg::CMD_W-1:0]          in_command,
  input  logic [str_pkg::ADDR_W-1:0]         in_address,
  input  logic [str_pkg::DATA_W-1:0]         in_write_data,
  input  logic signed [str_pkg::COORD_W-1:0] in_u_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_v_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_d_start,
  input  logic signed [str_pkg::COORD_W-1:0] in_u_step,
  input  logic signed [str_pkg::COORD_W-1:0] in_v_step,
  input  logic signed [str_pkg::COORD_W-1:0] in_d_step,
  input  logic [str_pkg::X_W-1:0]            in_start_x,
  input  logic [str_pkg::COUNT_W-1:0]        in_pixel_count,
  input  logic                               in_new_span,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [str_pkg::X_W-1:0]            out_pixel_x,
  output logic [str_pkg::COLOR_W-1:0]        out_color,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [str_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [str_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import str_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   push_valid;
  entry_t push_entry;
  logic   push_ready;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH_LOG:    cfg_nxt.width_log     = cfg_data[LOG_W-1:0];
        CFG_HEIGHT_LOG:   cfg_nxt.height_log    = cfg_data[LOG_W-1:0];
        CFG_DITHER_EN:    cfg_nxt.dither_enable = cfg_data[0];
        CFG_SHADE_MASK_0: cfg_nxt.shade_mask[0] = cfg_data[MASK_W-1:0];
        CFG_SHADE_MASK_1: cfg_nxt.shade_mask[1] = cfg_data[MASK_W-1:0];
        CFG_SHADE_MASK_2: cfg_nxt.shade_mask[2] = cfg_data[MASK_W-1:0];
        CFG_SHADE_MASK_3: cfg_nxt.shade_mask[3] = cfg_data[MASK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_log     <= CFG_LOG_RESET;
      cfg_r.height_log    <= CFG_LOG_RESET;
      cfg_r.dither_enable <= 1'b0;
      cfg_r.shade_mask    <= {4{CFG_MASK_RESET}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  str_front #(
    .SHADE_ROWS (SHADE_ROWS),
    .MAX_SPAN   (MAX_SPAN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_u_start     (in_u_start),
    .in_v_start     (in_v_start),
    .in_d_start     (in_d_start),
    .in_u_step      (in_u_step),
    .in_v_step      (in_v_step),
    .in_d_step      (in_d_step),
    .in_start_x     (in_start_x),
    .in_pixel_count (in_pixel_count),
    .in_new_span    (in_new_span),
    .push_valid     (push_valid),
    .push_entry     (push_entry),
    .push_ready     (push_ready)
  );

  str_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  str_back #(
    .TEX_LOG_MAX (TEX_LOG_MAX),
    .SHADE_ROWS  (SHADE_ROWS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel_x (out_pixel_x),
    .out_color   (out_color),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

// File: design/str_checker.sv
// ----------------------------------------------------------------------------
// str_checker
// Port-level checks on the rasterizer top level, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module str_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_pixel_x,
  input logic [15:0] out_color,
  input logic        out_last
);

  // Coming out of reset nothing is pending on either side.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !in_stall))
    else $error("outputs not idle after reset");

  // A stalled pixel holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pixel_x) && $stable(out_color) && $stable(out_last)))
    else $error("stalled pixel changed");

  // Pixels of one span piece follow back to back on consecutive columns.
  a_span_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && (out_pixel_x == 12'($past(out_pixel_x) + 12'd1))))
    else $error("span pixel missing or out of sequence");

endmodule

bind shaded_texture_span_rasterizer_top str_checker u_str_checker (.*);

`default_nettype wire
